@@ rtl/core/gmcc_pkg.sv @@
// Shared types, constants and the constant log2 table of the gamma and colour
// matrix unit. No dependencies; every other file of the block uses this package.
`default_nettype none

package gmcc_pkg;

  // Pixel code width and the full-scale code used for normalisation.
  localparam int PIXEL_BITS = 8;
  localparam int PIX_CODES  = 1 << PIXEL_BITS;
  localparam int PIX_MAX    = PIX_CODES - 1;

  // Field widths.
  localparam int GAMMA_W = 16;
  localparam int LOG_W   = 20;
  localparam int LG_W    = LOG_W + GAMMA_W + 1;
  localparam int P_W     = LG_W - 12;
  localparam int N_W     = P_W - 16;
  localparam int Y_W     = 30;
  localparam int Q30_W   = 31;
  localparam int SUM_W   = 31;
  localparam int RND_W   = 32;
  localparam int LIN_W   = 17;
  localparam int COEF_W  = 21;
  localparam int EST_W   = 23;
  localparam int ERR_W   = 22;
  localparam int PROD_W  = COEF_W + LIN_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int CHANS   = 3;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int GBGR_W     = CHANS * GAMMA_W;
  localparam int ROW_W      = CHANS * COEF_W;

  localparam logic [GBGR_W-1:0] GAMMA_RESET = 48'h1333_1333_1333;

  // Exponential series constants in Q.30; linear output constants in Q1.16.
  localparam int NTERMS = 9;
  localparam logic [Y_W-1:0]   LN2_Q30 = 30'd744261118;
  localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam int LIN_FRAC = 16;
  localparam logic [LIN_W-1:0] LIN_ONE = 17'h1_0000;

  // Estimate rounding and saturation limits.
  localparam int EST_SHIFT = 16;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(32768);
  localparam logic signed [EST_W-1:0] EST_MAX = 23'sh3F_FFFF;
  localparam logic signed [EST_W-1:0] EST_MIN = -23'sh40_0000;
  localparam logic [ERR_W-1:0] ERR_MAX = 22'h3F_FFFF;

  // Pipeline depths: the lane runs the table, the gamma product, the series
  // argument, one multiply and one divide stage per term, a final add and the
  // output shift; the matrix runs products, sum and error.
  localparam int LANE_LAT = 5 + 2 * NTERMS;
  localparam int MIX_LAT  = 3;
  localparam int PIPE_LAT = LANE_LAT + MIX_LAT;
  localparam int REF_LAT  = PIPE_LAT - 1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAMMA = 2'd0,
    REG_ROW_X = 2'd1,
    REG_ROW_Y = 2'd2,
    REG_ROW_Z = 2'd3
  } cfg_reg_t;

  // Special outcomes of the linearisation that bypass the series.
  typedef enum logic [1:0] {
    SPEC_NONE,
    SPEC_ONE,
    SPEC_ZERO
  } lin_spec_t;

  typedef logic [LIN_W-1:0]         lin_t;
  typedef logic signed [EST_W-1:0]  est_t;
  typedef logic [ERR_W-1:0]         err_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [LOG_W-1:0]         log_table_t [PIX_CODES];

  // Log2 in Q.16: integer part from the leading one, fraction bits by
  // repeated squaring of a Q1.30 mantissa. Used at elaboration only.
  function automatic logic [31:0] log2_q16(input logic [31:0] x);
    logic [63:0] m;
    logic [31:0] r;
    logic [4:0]  p;
    p = '0;
    for (int i = 1; i < 32; i++) begin
      if ((x >> i) != 32'd0) begin
        p = 5'(i);
      end
    end
    m = 64'(x) << (6'd30 - 6'(p));
    r = 32'(p) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        r[i] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  // Table of log2(full scale) - log2(code), clamped at zero.
  function automatic log_table_t build_log_table();
    log_table_t t;
    logic [31:0] lm;
    logic [31:0] lx;
    lm = log2_q16(32'(PIX_MAX));
    for (int c = 0; c < PIX_CODES; c++) begin
      lx = log2_q16(32'(c));
      t[c] = (c != 0 && lm > lx) ? LOG_W'(lm - lx) : '0;
    end
    return t;
  endfunction

  localparam log_table_t LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

@@ rtl/core/gmcc_if.sv @@
// Channel interfaces of the gamma and colour matrix unit: pixel input,
// result output and configuration write. Depends on gmcc_pkg.
`default_nettype none

interface gmcc_pix_if;
  logic                             valid;
  logic                             ready;
  logic [gmcc_pkg::PIXEL_BITS-1:0]  pix_b;
  logic [gmcc_pkg::PIXEL_BITS-1:0]  pix_g;
  logic [gmcc_pkg::PIXEL_BITS-1:0]  pix_r;
  logic signed [gmcc_pkg::EST_W-1:0] ref_x;
  logic signed [gmcc_pkg::EST_W-1:0] ref_y;
  logic signed [gmcc_pkg::EST_W-1:0] ref_z;

  modport source (output valid, pix_b, pix_g, pix_r, ref_x, ref_y, ref_z, input ready);
  modport sink   (input valid, pix_b, pix_g, pix_r, ref_x, ref_y, ref_z, output ready);
endinterface

interface gmcc_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [gmcc_pkg::EST_W-1:0] est_x;
  logic signed [gmcc_pkg::EST_W-1:0] est_y;
  logic signed [gmcc_pkg::EST_W-1:0] est_z;
  logic [gmcc_pkg::ERR_W-1:0]        err_x;
  logic [gmcc_pkg::ERR_W-1:0]        err_y;
  logic [gmcc_pkg::ERR_W-1:0]        err_z;

  modport source (output valid, est_x, est_y, est_z, err_x, err_y, err_z, input ready);
  modport sink   (input valid, est_x, est_y, est_z, err_x, err_y, err_z, output ready);
endinterface

interface gmcc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gmcc_pkg::CFG_IDX_W-1:0]    index;
  logic [gmcc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gmcc_lane.sv @@
// One colour lane: constant log2 table, gamma product and a pipelined
// exp2 series giving the linear value in Q1.16. Depends on gmcc_pkg.
`default_nettype none

module gmcc_lane (
  input  wire logic                            clk,
  input  wire logic                            adv,
  input  wire logic [gmcc_pkg::PIXEL_BITS-1:0] code,
  input  wire logic [gmcc_pkg::GAMMA_W-1:0]    gamma,
  output gmcc_pkg::lin_t                       lin
);

  localparam int NT = gmcc_pkg::NTERMS;

  // Stage 0: table lookup and classification of the special cases.
  logic [gmcc_pkg::LOG_W-1:0] logl;
  gmcc_pkg::lin_spec_t        sp0;
  gmcc_pkg::lin_spec_t        sp0_next;

  always_comb begin
    priority if (gamma == '0) begin
      sp0_next = gmcc_pkg::SPEC_ONE;
    end else if (code == '0) begin
      sp0_next = gmcc_pkg::SPEC_ZERO;
    end else begin
      sp0_next = gmcc_pkg::SPEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logl <= gmcc_pkg::LOG_TABLE[code];
      sp0  <= sp0_next;
    end
  end

  // Stage 1: exponent P = (L * gamma + half) >> 12.
  logic [gmcc_pkg::LG_W-1:0] lg_prod;
  logic [gmcc_pkg::P_W-1:0]  pexp;
  gmcc_pkg::lin_spec_t       sp1;

  assign lg_prod = gmcc_pkg::LG_W'(logl) * gmcc_pkg::LG_W'(gamma) + gmcc_pkg::LG_W'(2048);

  always_ff @(posedge clk) begin
    if (adv) begin
      pexp <= gmcc_pkg::P_W'(lg_prod >> 12);
      sp1  <= sp0;
    end
  end

  // Stage 2: series argument y = frac(P) * ln2 in Q.30, integer part kept.
  logic [gmcc_pkg::Y_W+15:0]  y_prod;
  logic [gmcc_pkg::Y_W-1:0]   y0;
  logic [gmcc_pkg::N_W-1:0]   n0;
  gmcc_pkg::lin_spec_t        sp2;

  assign y_prod = (gmcc_pkg::Y_W + 16)'(pexp[15:0]) * (gmcc_pkg::Y_W + 16)'(gmcc_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      y0  <= gmcc_pkg::Y_W'(y_prod >> 16);
      n0  <= pexp[gmcc_pkg::P_W-1:16];
      sp2 <= sp1;
    end
  end

  // Series stages: for each term a multiply stage and a divide-by-k stage.
  logic [gmcc_pkg::Y_W-1:0]   prod  [NT];
  logic [gmcc_pkg::Y_W-1:0]   term  [NT];
  logic [gmcc_pkg::Y_W-1:0]   y_m   [NT];
  logic [gmcc_pkg::Y_W-1:0]   y_d   [NT];
  logic [gmcc_pkg::N_W-1:0]   n_m   [NT];
  logic [gmcc_pkg::N_W-1:0]   n_d   [NT];
  gmcc_pkg::lin_spec_t        sp_m  [NT];
  gmcc_pkg::lin_spec_t        sp_d  [NT];
  logic [gmcc_pkg::SUM_W-1:0] sum_m [NT];
  logic [gmcc_pkg::SUM_W-1:0] sum_d [NT];

  for (genvar k = 0; k < NT; k++) begin : g_term
    // Exact division by the term number through a reciprocal multiply.
    localparam int DIVK = k + 1;
    localparam int SH   = gmcc_pkg::Y_W + $clog2(DIVK);
    localparam logic [gmcc_pkg::Y_W+1:0] RECIP =
      (gmcc_pkg::Y_W + 2)'(((64'd1 << SH) + 64'(DIVK) - 64'd1) / 64'(DIVK));

    logic [gmcc_pkg::Q30_W-1:0]          term_in;
    logic [gmcc_pkg::Y_W-1:0]            y_in;
    logic [gmcc_pkg::N_W-1:0]            n_in;
    gmcc_pkg::lin_spec_t                 sp_in;
    logic [gmcc_pkg::SUM_W-1:0]          sum_in;
    logic [gmcc_pkg::Q30_W+gmcc_pkg::Y_W-1:0] mul;
    logic [2*gmcc_pkg::Y_W+1:0]          dmul;

    if (k == 0) begin : g_first
      assign term_in = gmcc_pkg::ONE_Q30;
      assign y_in    = y0;
      assign n_in    = n0;
      assign sp_in   = sp2;
      assign sum_in  = gmcc_pkg::SUM_W'(gmcc_pkg::ONE_Q30);
    end else begin : g_next
      assign term_in = gmcc_pkg::Q30_W'(term[k-1]);
      assign y_in    = y_d[k-1];
      assign n_in    = n_d[k-1];
      assign sp_in   = sp_d[k-1];
      // Odd terms are subtracted, even terms added.
      if ((k % 2) == 1) begin : g_sub
        assign sum_in = sum_d[k-1] - gmcc_pkg::SUM_W'(term[k-1]);
      end else begin : g_add
        assign sum_in = sum_d[k-1] + gmcc_pkg::SUM_W'(term[k-1]);
      end
    end

    assign mul  = (gmcc_pkg::Q30_W + gmcc_pkg::Y_W)'(term_in)
                * (gmcc_pkg::Q30_W + gmcc_pkg::Y_W)'(y_in);
    assign dmul = (2 * gmcc_pkg::Y_W + 2)'(prod[k]) * (2 * gmcc_pkg::Y_W + 2)'(RECIP);

    always_ff @(posedge clk) begin
      if (adv) begin
        prod[k]  <= gmcc_pkg::Y_W'(mul >> 30);
        sum_m[k] <= sum_in;
        y_m[k]   <= y_in;
        n_m[k]   <= n_in;
        sp_m[k]  <= sp_in;
        term[k]  <= gmcc_pkg::Y_W'(dmul >> SH);
        sum_d[k] <= sum_m[k];
        y_d[k]   <= y_m[k];
        n_d[k]   <= n_m[k];
        sp_d[k]  <= sp_m[k];
      end
    end
  end

  // Final stage of the series: fold in the last term.
  logic [gmcc_pkg::SUM_W-1:0] sum_f;
  logic [gmcc_pkg::SUM_W-1:0] sum_f_next;
  logic [gmcc_pkg::N_W-1:0]   n_f;
  gmcc_pkg::lin_spec_t        sp_f;

  if ((NT % 2) == 1) begin : g_last_sub
    assign sum_f_next = sum_d[NT-1] - gmcc_pkg::SUM_W'(term[NT-1]);
  end else begin : g_last_add
    assign sum_f_next = sum_d[NT-1] + gmcc_pkg::SUM_W'(term[NT-1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_f <= sum_f_next;
      n_f   <= n_d[NT-1];
      sp_f  <= sp_d[NT-1];
    end
  end

  // Output stage: scale by 2^-n with rounding, apply the special cases.
  logic [4:0]                 nsh;
  logic [gmcc_pkg::RND_W-1:0] rnd_sum;
  gmcc_pkg::lin_t             lin_val;
  gmcc_pkg::lin_t             lin_next;

  assign nsh     = n_f[4:0];
  assign rnd_sum = gmcc_pkg::RND_W'(sum_f) + (gmcc_pkg::RND_W'(1) << (6'd13 + 6'(nsh)));
  assign lin_val = gmcc_pkg::LIN_W'(rnd_sum >> (6'd14 + 6'(nsh)));

  always_comb begin
    unique case (sp_f)
      gmcc_pkg::SPEC_ONE:  lin_next = gmcc_pkg::LIN_ONE;
      gmcc_pkg::SPEC_ZERO: lin_next = '0;
      default: begin
        lin_next = (n_f > gmcc_pkg::N_W'(gmcc_pkg::LIN_FRAC)) ? '0 : lin_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin <= lin_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gmcc_mix.sv @@
// Merging stage: 3x3 colour matrix over the lane outputs, rounding,
// saturation and absolute error against the reference. Depends on gmcc_pkg.
`default_nettype none

module gmcc_mix (
  input  wire logic           clk,
  input  wire logic           adv,
  input  wire gmcc_pkg::lin_t lin  [gmcc_pkg::CHANS],
  input  wire gmcc_pkg::row_t rows [gmcc_pkg::CHANS],
  input  wire gmcc_pkg::est_t tgt  [gmcc_pkg::CHANS],
  output gmcc_pkg::est_t      est  [gmcc_pkg::CHANS],
  output gmcc_pkg::err_t      err  [gmcc_pkg::CHANS]
);

  localparam int NC = gmcc_pkg::CHANS;

  logic signed [gmcc_pkg::PROD_W-1:0] prod [NC][NC];
  gmcc_pkg::est_t                     est1 [NC];

  for (genvar r = 0; r < NC; r++) begin : g_row
    // Products of one row, one multiplier per coefficient.
    for (genvar c = 0; c < NC; c++) begin : g_col
      logic signed [gmcc_pkg::COEF_W-1:0] coef_s;
      logic signed [gmcc_pkg::LIN_W:0]    lin_s;

      assign coef_s = signed'(rows[r][gmcc_pkg::COEF_W*c +: gmcc_pkg::COEF_W]);
      assign lin_s  = signed'({1'b0, lin[c]});

      always_ff @(posedge clk) begin
        if (adv) begin
          prod[r][c] <= gmcc_pkg::PROD_W'(coef_s) * gmcc_pkg::PROD_W'(lin_s);
        end
      end
    end

    // Row sum, round half up to 10 fraction bits, saturate.
    logic signed [gmcc_pkg::ACC_W-1:0] acc;
    logic signed [gmcc_pkg::ACC_W-1:0] est_raw;
    gmcc_pkg::est_t                    est_sat;

    assign acc = gmcc_pkg::ACC_W'(prod[r][0]) + gmcc_pkg::ACC_W'(prod[r][1])
               + gmcc_pkg::ACC_W'(prod[r][2]) + gmcc_pkg::ACC_ROUND;
    assign est_raw = acc >>> gmcc_pkg::EST_SHIFT;

    always_comb begin
      priority if (est_raw > gmcc_pkg::ACC_W'(gmcc_pkg::EST_MAX)) begin
        est_sat = gmcc_pkg::EST_MAX;
      end else if (est_raw < gmcc_pkg::ACC_W'(gmcc_pkg::EST_MIN)) begin
        est_sat = gmcc_pkg::EST_MIN;
      end else begin
        est_sat = gmcc_pkg::EST_W'(est_raw);
      end
    end

    // Absolute difference from the reference, saturated.
    logic signed [gmcc_pkg::EST_W:0] diff;
    logic [gmcc_pkg::EST_W:0]        mag;

    assign diff = (gmcc_pkg::EST_W + 1)'(est1[r]) - (gmcc_pkg::EST_W + 1)'(tgt[r]);
    assign mag  = diff[gmcc_pkg::EST_W] ? (gmcc_pkg::EST_W + 1)'(-diff)
                                        : (gmcc_pkg::EST_W + 1)'(diff);

    always_ff @(posedge clk) begin
      if (adv) begin
        est1[r] <= est_sat;
        est[r]  <= est1[r];
        err[r]  <= (mag > (gmcc_pkg::EST_W + 1)'(gmcc_pkg::ERR_MAX)) ? gmcc_pkg::ERR_MAX
                                                                  : mag[gmcc_pkg::ERR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gamma_matrix_color_convert_unit.sv @@
// Each pixel passes the lane stages, then the matrix stages, then the output register.
// Throughput: one pixel per cycle unless the output stalls; each of the three lanes runs
// the exp2 series as nine multiply and divide stage pairs; the matrix stage follows them.
// Reset clears the pipeline valid bits, the output valid flag and the configuration
// registers to their defaults; no clearing pass is needed.
// Depends on gmcc_pkg, gmcc_if, gmcc_lane and gmcc_mix.
`default_nettype none

module gamma_matrix_color_convert_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  gmcc_pix_if.sink   pix,
  gmcc_res_if.source res,
  gmcc_cfg_if.sink   cfg
);

  localparam int NC = gmcc_pkg::CHANS;

  // Configuration registers; writes are always taken.
  logic [gmcc_pkg::GBGR_W-1:0] gamma_bgr;
  gmcc_pkg::row_t              matrix_row [NC];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_bgr <= gmcc_pkg::GAMMA_RESET;
      for (int i = 0; i < NC; i++) begin
        matrix_row[i] <= '0;
      end
    end else if (cfg.valid && cfg.ready) begin
      unique case (gmcc_pkg::cfg_reg_t'(cfg.index))
        gmcc_pkg::REG_GAMMA: gamma_bgr     <= cfg.data[gmcc_pkg::GBGR_W-1:0];
        gmcc_pkg::REG_ROW_X: matrix_row[0] <= cfg.data[gmcc_pkg::ROW_W-1:0];
        gmcc_pkg::REG_ROW_Y: matrix_row[1] <= cfg.data[gmcc_pkg::ROW_W-1:0];
        gmcc_pkg::REG_ROW_Z: matrix_row[2] <= cfg.data[gmcc_pkg::ROW_W-1:0];
      endcase
    end
  end

  // Pipeline control: the pipeline moves unless its last stage holds a result
  // that the full output register cannot take.
  logic [gmcc_pkg::PIPE_LAT-1:0] vld;
  logic                          adv;
  logic                          in_take;
  logic                          out_load;
  logic                          out_valid;

  assign adv       = !vld[gmcc_pkg::PIPE_LAT-1] || !out_valid || res.ready;
  assign pix.ready = adv;
  assign in_take   = pix.valid && adv;
  assign out_load  = vld[gmcc_pkg::PIPE_LAT-1] && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[gmcc_pkg::PIPE_LAT-2:0], in_take};
    end
  end

  // Colour lanes, blue, green, red.
  logic [gmcc_pkg::PIXEL_BITS-1:0] codes [NC];
  gmcc_pkg::lin_t                  lin   [NC];

  assign codes[0] = pix.pix_b;
  assign codes[1] = pix.pix_g;
  assign codes[2] = pix.pix_r;

  for (genvar c = 0; c < NC; c++) begin : g_lane
    gmcc_lane u_lane (
      .clk   (clk),
      .adv   (adv),
      .code  (codes[c]),
      .gamma (gamma_bgr[gmcc_pkg::GAMMA_W*c +: gmcc_pkg::GAMMA_W]),
      .lin   (lin[c])
    );
  end

  // Reference delay line, aligned with the error stage of the matrix.
  gmcc_pkg::est_t ref_pipe [gmcc_pkg::REF_LAT][NC];

  always_ff @(posedge clk) begin
    if (adv) begin
      ref_pipe[0][0] <= pix.ref_x;
      ref_pipe[0][1] <= pix.ref_y;
      ref_pipe[0][2] <= pix.ref_z;
      for (int s = 1; s < gmcc_pkg::REF_LAT; s++) begin
        ref_pipe[s] <= ref_pipe[s-1];
      end
    end
  end

  // Matrix and error stage.
  gmcc_pkg::est_t est [NC];
  gmcc_pkg::err_t err [NC];

  gmcc_mix u_mix (
    .clk  (clk),
    .adv  (adv),
    .lin  (lin),
    .rows (matrix_row),
    .tgt  (ref_pipe[gmcc_pkg::REF_LAT-1]),
    .est  (est),
    .err  (err)
  );

  // Output register.
  gmcc_pkg::est_t est_out [NC];
  gmcc_pkg::err_t err_out [NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      est_out <= est;
      err_out <= err;
    end
  end

  assign res.valid = out_valid;
  assign res.est_x = est_out[0];
  assign res.est_y = est_out[1];
  assign res.est_z = est_out[2];
  assign res.err_x = err_out[0];
  assign res.err_y = err_out[1];
  assign res.err_z = err_out[2];

endmodule

`default_nettype wire

@@ rtl/core/gmcc_checker.sv @@
// Port-level checks of the gamma and colour matrix unit, attached to the top
// level by a bind statement. Depends on gmcc_pkg.
`default_nettype none

module gmcc_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 cfg_ready,
  input wire gmcc_pkg::est_t       est_x,
  input wire gmcc_pkg::est_t       est_y,
  input wire gmcc_pkg::est_t       est_z,
  input wire gmcc_pkg::err_t       err_x,
  input wire gmcc_pkg::err_t       err_y,
  input wire gmcc_pkg::err_t       err_z
);

  // A result waiting at the output keeps its value until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(est_x) && $stable(est_y)
      && $stable(est_z) && $stable(err_x) && $stable(err_y) && $stable(err_z))
    else $error("result changed while stalled");

  // The input only pushes back when a result is waiting and not being taken.
  a_in_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind gamma_matrix_color_convert_unit gmcc_checker u_gmcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .cfg_ready (cfg.ready),
  .est_x     (res.est_x),
  .est_y     (res.est_y),
  .est_z     (res.est_z),
  .err_x     (res.err_x),
  .err_y     (res.err_y),
  .err_z     (res.err_z)
);

`default_nettype wire
